// ===== sv/qps_pkg.sv =====
// qps_pkg: shared constants, codes and types for the quadrature position sampler.
// No dependencies; every other file of the block but qps_ram imports it.
package qps_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam int CQ_DEPTH   = 4;
    localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);

    localparam int KIND_W     = 2;
    localparam int POS_W      = 16;
    localparam int PERIOD_W   = 16;

    localparam logic [POS_W-1:0]    POS_RESET    = 16'd32768;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd12499;

    typedef enum logic [KIND_W-1:0] {
        KIND_EDGE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

endpackage

// ===== sv/qps_ram.sv =====
// qps_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module qps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/qps_front.sv =====
// qps_front: input side; classifies requests, keeps the position and period counters.
// Depends on qps_pkg.
module qps_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [qps_pkg::KIND_W-1:0]     i_kind,
    input  logic                           i_a_level,
    input  logic                           i_b_level,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qps_pkg::PERIOD_W-1:0]   i_cfg_sample_period,
    input  logic                           i_q_full,
    output qps_pkg::t_cmd_req              o_req
);
    import qps_pkg::*;

    logic [PERIOD_W-1:0] r_sample_period;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic                accept;

    assign o_stall     = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !i_q_full;

    always_comb begin
        n_pos             = r_pos;
        n_period          = r_period;
        o_req.valid       = 1'b0;
        o_req.cmd.op      = OP_PUSH;
        o_req.cmd.value   = r_pos;
        if (accept) begin
            case (t_kind'(i_kind))
                KIND_EDGE: begin
                    // up when A and B differ, down when equal
                    if (i_a_level != i_b_level) begin
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        n_pos = r_pos - POS_W'(1);
                    end
                end
                KIND_TICK: begin
                    if (r_period == r_sample_period) begin
                        n_period    = '0;
                        o_req.valid = 1'b1;
                    end else begin
                        n_period = r_period + PERIOD_W'(1);
                    end
                end
                KIND_READ: begin
                    o_req.valid  = 1'b1;
                    o_req.cmd.op = OP_READ;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= PERIOD_RESET;
            r_pos           <= POS_RESET;
            r_period        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_sample_period <= i_cfg_sample_period;
            end
            r_pos    <= n_pos;
            r_period <= n_period;
        end
    end
endmodule

// ===== sv/qps_cmdq.sv =====
// qps_cmdq: short in-order command queue between the front and the back.
// Depends on qps_pkg.
module qps_cmdq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qps_pkg::t_cmd_req  i_req,
    output logic               o_full,
    output qps_pkg::t_cmd_req  o_head,
    input  logic               i_pop
);
    import qps_pkg::*;

    localparam logic [CQ_PTR_W-1:0] CQ_LAST = CQ_PTR_W'(CQ_DEPTH - 1);
    localparam logic [CQ_CNT_W-1:0] CQ_FULL = CQ_CNT_W'(CQ_DEPTH);

    t_cmd                r_slot [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr, r_rd;
    logic [CQ_CNT_W-1:0] r_count;
    logic                do_pop;

    assign o_full       = (r_count == CQ_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rd];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_slot[r_wr] <= i_req.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_req.valid) begin
                r_wr <= (r_wr == CQ_LAST) ? '0 : r_wr + CQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == CQ_LAST) ? '0 : r_rd + CQ_PTR_W'(1);
            end
            r_count <= r_count + CQ_CNT_W'(i_req.valid) - CQ_CNT_W'(do_pop);
        end
    end

    // the front stalls on full, so nothing is ever written into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> (r_count != CQ_FULL))
        else $error("command queue overflow");
endmodule

// ===== sv/qps_back.sv =====
// qps_back: executes queued pushes and reads against the sample FIFO, drives results.
// Depends on qps_pkg and qps_ram.
module qps_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qps_pkg::t_cmd_req           i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [qps_pkg::POS_W-1:0]   o_position,
    output logic                        o_read_status
);
    import qps_pkg::*;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);

    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_s1_valid, r_s1_status;
    logic [POS_W-1:0]  ram_rdata;

    logic [POS_W-1:0]  r_ob_pos  [2];
    logic              r_ob_stat [2];
    logic              r_ob_head, r_ob_tail;
    logic [1:0]        r_ob_cnt;

    logic              out_pop, issue_ok, is_read;
    logic              do_push, do_read, ram_re;
    logic [2:0]        occupancy;
    logic [POS_W-1:0]  s1_pos;

    assign out_pop   = (r_ob_cnt != 2'd0) && !i_stall;
    assign occupancy = 3'(r_s1_valid) + 3'(r_ob_cnt);
    // room for one more result counting what is in flight and what drains now
    assign issue_ok  = (occupancy < 3'd2) || out_pop;
    assign is_read   = (i_head.cmd.op == OP_READ);
    assign o_pop     = i_head.valid && (!is_read || issue_ok);
    assign do_push   = o_pop && !is_read && (r_fill != FILL_FULL);
    assign do_read   = o_pop && is_read;
    assign ram_re    = do_read && (r_fill != '0);

    always_comb begin
        n_fill = r_fill;
        if (do_push) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (ram_re) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    qps_ram #(
        .WIDTH (POS_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_head.cmd.value),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign s1_pos = r_s1_status ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_status <= 1'b0;
            r_ob_head   <= 1'b0;
            r_ob_tail   <= 1'b0;
            r_ob_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (ram_re) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_fill      <= n_fill;
            r_s1_valid  <= do_read;
            r_s1_status <= ram_re;
            if (r_s1_valid) begin
                r_ob_tail <= ~r_ob_tail;
            end
            if (out_pop) begin
                r_ob_head <= ~r_ob_head;
            end
            r_ob_cnt <= r_ob_cnt + 2'(r_s1_valid) - 2'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_ob_pos[r_ob_tail]  <= s1_pos;
            r_ob_stat[r_ob_tail] <= r_s1_status;
        end
    end

    assign o_valid       = (r_ob_cnt != 2'd0);
    assign o_position    = r_ob_pos[r_ob_head];
    assign o_read_status = r_ob_stat[r_ob_head];

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("sample FIFO fill level out of range");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= 3'd2)
        else $error("more results in flight than the output buffer holds");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !is_read && r_fill == FILL_FULL) |=> $stable(r_fill))
        else $error("push into a full FIFO changed its fill level");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_read |=> ##1 (r_ob_cnt != 2'd0))
        else $error("read request produced no result");
endmodule

// ===== sv/quadrature_2x_position_sampler.sv =====
// quadrature_2x_position_sampler: top level of the 2x quadrature position sampler.
// Depends on qps_pkg, qps_front, qps_cmdq and qps_back.
//
// Usage:
//   Input channel (i_valid / o_stall): one request per accepted cycle. i_kind
//   selects a channel-A edge (with i_a_level, i_b_level), a timer tick, or a
//   read of one sample; the unused kind code is taken and ignored.
//   Output channel (o_valid / i_stall): one result per read request, carrying
//   the oldest sampled position and o_read_status (1 sample, 0 FIFO empty,
//   position then 0). Edges and ticks give no result.
//   Configuration channel (i_cfg_valid / o_cfg_ready): writes sample_period;
//   ready is always high. Write only while the block is idle.
// Throughput: one request per cycle while o_stall is low, edges, ticks and reads mixed.
// Read path: a read result passes the command queue, the registered sample RAM
//   read and the two-entry output buffer, in that order, before it is shown.
// Reset (synchronous, active low): position count 32768, period count 0,
//   sample_period 12499, FIFO empty; no clearing pass, the first request is
//   taken in the cycle after reset releases.
// Receiver stall: results collect in a two-entry output buffer, then reads wait
//   in the four-entry command queue; once the queue is full, o_stall rises and
//   holds the input side. Edges and ticks keep counting up to that point.
module quadrature_2x_position_sampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [qps_pkg::KIND_W-1:0]     i_kind,
    input  logic                           i_a_level,
    input  logic                           i_b_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [qps_pkg::POS_W-1:0]      o_position,
    output logic                           o_read_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qps_pkg::PERIOD_W-1:0]   i_cfg_sample_period
);
    import qps_pkg::*;

    t_cmd_req req;     // front to queue: push sample or read
    t_cmd_req head;    // queue head to back
    logic     q_full;
    logic     q_pop;

    // Front: counters and request classification
    qps_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_kind              (i_kind),
        .i_a_level           (i_a_level),
        .i_b_level           (i_b_level),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_sample_period (i_cfg_sample_period),
        .i_q_full            (q_full),
        .o_req               (req)
    );

    // Queue: keeps pushes and reads in request order
    qps_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (q_pop)
    );

    // Back: sample FIFO and result delivery
    qps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_position    (o_position),
        .o_read_status (o_read_status)
    );
endmodule
